// File: hw/rtl/faro_pkg.sv
package faro_pkg;

    localparam int MAX_CARDS  = 64;
    localparam int CARD_BITS  = 8;
    localparam int POS_BITS   = 16;
    localparam int IDX_BITS   = 6;
    localparam int COUNT_BITS = 7;
    localparam int PASS_BITS  = 5;
    localparam int BSEL_BITS  = 4;

    localparam logic [COUNT_BITS-1:0] DECK_RESET = 7'd52;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_SHUFFLE = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [IDX_BITS-1:0]  card_index;
        logic [CARD_BITS-1:0] card_value;
        logic [POS_BITS-1:0]  position;
    } item_t;

    typedef struct packed {
        logic [CARD_BITS-1:0] card_out;
        logic [PASS_BITS-1:0] passes_done;
        logic                 status;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHUF,
        ST_FLUSH
    } state_t;

endpackage

// File: hw/rtl/faro_shuffle_sequencer_unit.sv
// channel  | handshake                    | beat
// item     | item_valid / item_stall      | faro_pkg::item_t
// result   | result_valid / result_stall  | faro_pkg::result_t
// config   | cfg_we                       | cfg_wdata (deck_count)
//
// Write, op 3, an out-of-range read and a shuffle with position 0 answer straight
// from ST_IDLE; an in-range read first passes through ST_READ for the deck memory read.
// A shuffle runs its passes in ST_SHUF: each pass copies one slot
// per cycle through the source bank's read port, then ST_FLUSH lands the last write.
// Reset selects bank a and sets deck_count to 52; deck contents are undefined.
// A new item waits while a result is held under result_stall.
module faro_shuffle_sequencer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [faro_pkg::COUNT_BITS-1:0]     cfg_wdata,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  faro_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output faro_pkg::result_t                   result
);
    import faro_pkg::*;

    logic [CARD_BITS-1:0] bank_a [MAX_CARDS];
    logic [CARD_BITS-1:0] bank_b [MAX_CARDS];
    logic [CARD_BITS-1:0] rd_a_reg;
    logic [CARD_BITS-1:0] rd_b_reg;

    state_t               state_reg, state_next;
    logic                 active_reg, active_next;
    logic [COUNT_BITS-1:0] deck_count_reg;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [BSEL_BITS-1:0] bit_reg, bit_next;
    logic [PASS_BITS-1:0] passes_reg, passes_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [IDX_BITS-1:0]  wr_addr_reg, wr_addr_next;

    logic [COUNT_BITS-1:0] deck_n;
    logic                  accept;
    logic                  oob;
    logic [PASS_BITS-1:0]  top_len;
    logic                  in_pass;
    logic [COUNT_BITS-1:0] lead;
    logic [COUNT_BITS-1:0] lead_sum;
    logic [IDX_BITS-1:0]   src_idx;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [CARD_BITS-1:0]  rd_data;
    logic                  we_a, we_b;
    logic [IDX_BITS-1:0]   waddr;
    logic [CARD_BITS-1:0]  wdata;
    logic                  host_write;

    assign deck_n = (deck_count_reg > COUNT_BITS'(MAX_CARDS)) ?
                    COUNT_BITS'(MAX_CARDS) : deck_count_reg;

    assign item_stall   = !((state_reg == ST_IDLE) && (!result_valid_reg || !result_stall));
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign oob     = {1'b0, item.card_index} >= deck_n;
    assign rd_data = active_reg ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        top_len = '0;
        for (int b = 0; b < POS_BITS; b++)
        begin
            if (item.position[b])
                top_len = PASS_BITS'(b + 1);
        end
    end

    assign in_pass  = pos_reg[bit_reg];
    assign lead     = in_pass ? (deck_n >> 1) : ((deck_n + COUNT_BITS'(1)) >> 1);
    assign lead_sum = lead + COUNT_BITS'(idx_reg >> 1);

    always_comb
    begin
        if ({1'b0, idx_reg} >= deck_n)
            src_idx = idx_reg;
        else if ((idx_reg[0] == 1'b0) != in_pass)
            src_idx = idx_reg >> 1;
        else
            src_idx = lead_sum[IDX_BITS-1:0];
    end

    assign rd_addr    = (state_reg == ST_SHUF) ? src_idx : item.card_index;
    assign host_write = accept && (item.op == OP_WRITE) && !oob;

    always_comb
    begin
        if (wr_pend_reg)
        begin
            waddr = wr_addr_reg;
            wdata = rd_data;
            we_a  = active_reg;
            we_b  = !active_reg;
        end
        else
        begin
            waddr = item.card_index;
            wdata = item.card_value;
            we_a  = host_write && !active_reg;
            we_b  = host_write && active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
            bank_a[waddr] <= wdata;
        rd_a_reg <= bank_a[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            bank_b[waddr] <= wdata;
        rd_b_reg <= bank_b[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deck_count_reg <= DECK_RESET;
        else if (cfg_we)
            deck_count_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            wr_pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            result_valid_reg <= result_valid_next;
            wr_pend_reg      <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        pos_reg     <= pos_next;
        bit_reg     <= bit_next;
        passes_reg  <= passes_next;
        idx_reg     <= idx_next;
        wr_addr_reg <= wr_addr_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        pos_next          = pos_reg;
        bit_next          = bit_reg;
        passes_next       = passes_reg;
        idx_next          = idx_reg;
        wr_pend_next      = 1'b0;
        wr_addr_next      = wr_addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    unique case (item.op)
                        OP_WRITE:
                        begin
                            result_valid_next  = 1'b1;
                            result_next.status = oob;
                        end
                        OP_READ:
                        begin
                            if (oob)
                            begin
                                result_valid_next  = 1'b1;
                                result_next.status = 1'b1;
                            end
                            else
                                state_next = ST_READ;
                        end
                        OP_SHUFFLE:
                        begin
                            if (top_len == '0)
                                result_valid_next = 1'b1;
                            else
                            begin
                                pos_next    = item.position;
                                bit_next    = BSEL_BITS'(top_len - PASS_BITS'(1));
                                passes_next = top_len;
                                idx_next    = '0;
                                state_next  = ST_SHUF;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                result_valid_next    = 1'b1;
                result_next          = '0;
                result_next.card_out = rd_data;
                state_next           = ST_IDLE;
            end
            ST_SHUF:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = idx_reg;
                idx_next     = idx_reg + IDX_BITS'(1);
                if (idx_reg == IDX_BITS'(MAX_CARDS - 1))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                active_next = !active_reg;
                idx_next    = '0;
                if (bit_reg == '0)
                begin
                    result_valid_next       = 1'b1;
                    result_next             = '0;
                    result_next.passes_done = passes_reg;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - BSEL_BITS'(1);
                    state_next = ST_SHUF;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: test/tb_faro_shuffle_sequencer_unit.sv
module tb_faro_shuffle_sequencer_unit;
    import faro_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_BEATS = 185;
    localparam int MAX_WAIT = 17;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wdata = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;

    faro_shuffle_sequencer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    logic [CARD_BITS-1:0]  deck_m [2][MAX_CARDS];
    bit                    active_bank_m = 1'b0;
    logic [COUNT_BITS-1:0] deck_count_m = DECK_RESET;

    item_t   item_backlog [$];
    result_t deck_answers [$];
    int      items_queued = 0;
    int      answers_checked = 0;
    int      mismatches = 0;

    bit item_fire = 1'b0;
    bit res_fire = 1'b0;
    int item_gap = 0;
    int item_stretch = 0;
    bit item_calm = 1'b0;
    int res_wait = 0;
    int res_stretch = 0;
    bit res_calm = 1'b0;

    logic [COUNT_BITS-1:0] deck_plan [10] = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127,
                                              7'd33, 7'd65, 7'd63, 7'd51, 7'd64};

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int cards_in_play(input logic [COUNT_BITS-1:0] count);
        return (count > MAX_CARDS) ? MAX_CARDS : int'(count);
    endfunction

    function automatic result_t apply_deck_op(input item_t it);
        result_t r;
        int      n;
        int      lead;
        int      top;
        int      b;
        int      i;
        bit      in_pass;
        r = '0;
        n = cards_in_play(deck_count_m);
        case (it.op)
            OP_WRITE:
                if (it.card_index >= n)
                    r.status = 1'b1;
                else
                    deck_m[active_bank_m][it.card_index] = it.card_value;
            OP_READ:
                if (it.card_index >= n)
                    r.status = 1'b1;
                else
                    r.card_out = deck_m[active_bank_m][it.card_index];
            OP_SHUFFLE:
            begin
                top = -1;
                for (b = 0; b < POS_BITS; b++)
                    if (it.position[b])
                        top = b;
                for (b = top; b >= 0; b--)
                begin
                    in_pass = it.position[b];
                    lead = in_pass ? n / 2 : (n + 1) / 2;
                    for (i = 0; i < MAX_CARDS; i++)
                    begin
                        if (i >= n)
                            deck_m[!active_bank_m][i] = deck_m[active_bank_m][i];
                        else if (((i % 2) == 0) != in_pass)
                            deck_m[!active_bank_m][i] = deck_m[active_bank_m][i / 2];
                        else
                            deck_m[!active_bank_m][i] = deck_m[active_bank_m][lead + i / 2];
                    end
                    active_bank_m = !active_bank_m;
                    r.passes_done = r.passes_done + PASS_BITS'(1);
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic int draw_wait(inout int stretch, inout bit calm);
        if (stretch == 0)
        begin
            stretch = $urandom_range(16, 96);
            calm = ($urandom_range(0, 3) == 0);
        end
        stretch--;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic item_t make_item(input logic [1:0] op, input int idx,
                                        input int val, input int pos);
        item_t it;
        it.op = op;
        it.card_index = IDX_BITS'(idx);
        it.card_value = CARD_BITS'(val);
        it.position = POS_BITS'(pos);
        return it;
    endfunction

    function automatic item_t random_item(input int n);
        item_t               it;
        int                  sel;
        int                  len;
        logic [POS_BITS-1:0] top_bit;
        it = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            it.op = OP_WRITE;
        else if (sel < 75)
            it.op = OP_READ;
        else if (sel < 95)
            it.op = OP_SHUFFLE;
        else
            it.op = OP_UNUSED;
        if ((it.op == OP_WRITE || it.op == OP_READ) && n > 0 && $urandom_range(0, 9) != 0)
            it.card_index = IDX_BITS'($urandom_range(0, n - 1));
        if (it.op == OP_SHUFFLE)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                it.position = '0;
            else if (sel > 2)
            begin
                len = $urandom_range(1, 5);
                top_bit = '0;
                top_bit[len - 1] = 1'b1;
                it.position = top_bit | (it.position & (top_bit - POS_BITS'(1)));
            end
        end
        return it;
    endfunction

    task automatic queue_item(input item_t it);
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (answers_checked != items_queued);
    endtask

    task automatic load_deck_count(input logic [COUNT_BITS-1:0] count);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // item driver: hold a stalled beat, otherwise idle or present the next one
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_fire)
                item_gap = draw_wait(item_stretch, item_calm);
            if (item_valid && !item_fire)
                ;
            else if (item_gap > 0)
            begin
                item_gap--;
                item_valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                item <= item_backlog.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_fire)
                res_wait = draw_wait(res_stretch, res_calm);
            if (res_wait > 0)
            begin
                res_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : deck_monitor
        result_t want;
        if (!rst_n)
        begin
            active_bank_m = 1'b0;
            deck_count_m = DECK_RESET;
            item_fire <= 1'b0;
            res_fire <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                deck_count_m = cfg_wdata;
            item_fire <= item_valid && !item_stall;
            res_fire <= result_valid && !result_stall;
            if (item_valid && !item_stall)
                deck_answers.push_back(apply_deck_op(item));
            if (result_valid && !result_stall)
            begin
                if (deck_answers.size() == 0)
                    log_mismatch("result beat with nothing outstanding");
                else
                begin
                    want = deck_answers.pop_front();
                    answers_checked++;
                    if (result.card_out !== want.card_out)
                        log_mismatch($sformatf("card_out %0h, want %0h",
                                               result.card_out, want.card_out));
                    if (result.passes_done !== want.passes_done)
                        log_mismatch($sformatf("passes_done %0d, want %0d",
                                               result.passes_done, want.passes_done));
                    if (result.status !== want.status)
                        log_mismatch($sformatf("status %0b, want %0b",
                                               result.status, want.status));
                end
            end
        end
    end

    initial
    begin
        int                    p;
        int                    k;
        int                    n;
        logic [COUNT_BITS-1:0] count;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(make_item(OP_WRITE, 0, 'hFF, $urandom));
        queue_item(make_item(OP_WRITE, 51, 'h00, $urandom));
        queue_item(make_item(OP_WRITE, 52, 'hAA, $urandom));
        queue_item(make_item(OP_WRITE, 63, 'h55, $urandom));
        queue_item(make_item(OP_READ, 0, $urandom, $urandom));
        queue_item(make_item(OP_READ, 51, $urandom, $urandom));
        queue_item(make_item(OP_READ, 52, $urandom, $urandom));
        queue_item(make_item(OP_READ, 63, $urandom, $urandom));
        queue_item(make_item(OP_UNUSED, 63, 'hFF, 'hFFFF));

        // fill bank a, then one pass so bank b holds known cards too
        load_deck_count(7'd64);
        for (k = 0; k < MAX_CARDS; k++)
            queue_item(make_item(OP_WRITE, k, $urandom, $urandom));
        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'h0001));

        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'h0000));
        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'hFFFF));
        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'h8000));
        queue_item(make_item(OP_READ, 0, $urandom, $urandom));
        queue_item(make_item(OP_READ, 63, $urandom, $urandom));
        queue_item(make_item(OP_WRITE, 63, 'hFF, $urandom));
        queue_item(make_item(OP_READ, 63, $urandom, $urandom));

        load_deck_count(7'd33);
        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'h0002));
        queue_item(make_item(OP_READ, 0, $urandom, $urandom));
        queue_item(make_item(OP_READ, 32, $urandom, $urandom));
        queue_item(make_item(OP_READ, 33, $urandom, $urandom));
        queue_item(make_item(OP_SHUFFLE, $urandom, $urandom, 'h0001));

        for (p = 0; p < 10; p++)
        begin
            count = (p == 9) ? COUNT_BITS'($urandom_range(1, MAX_CARDS)) : deck_plan[p];
            load_deck_count(count);
            n = cards_in_play(count);
            for (k = 0; k < PHASE_BEATS; k++)
                queue_item(random_item(n));
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (deck_answers.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", deck_answers.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
